>>> rtl/hrdt_pkg.sv
`timescale 1ns / 1ps
package hrdt_pkg;

    localparam int HANDLE_W = 16;
    localparam int COUNT_W  = 16;
    localparam int DCNT_W   = 4;

    localparam logic [2:0] REQ_OPEN   = 3'd0;
    localparam logic [2:0] REQ_CLOSE  = 3'd1;
    localparam logic [2:0] REQ_QUERY  = 3'd2;
    localparam logic [2:0] REQ_ADD    = 3'd3;
    localparam logic [2:0] REQ_REMOVE = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_TABLE_FULL = 3'd1;
    localparam logic [2:0] ST_NO_OWNER   = 3'd2;
    localparam logic [2:0] ST_LIST_FULL  = 3'd3;
    localparam logic [2:0] ST_NOT_HELD   = 3'd4;
    localparam logic [2:0] ST_INVALID    = 3'd5;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

endpackage

>>> rtl/handle_refcount_device_table.sv
`timescale 1ns / 1ps
// channel  | signals                                              | handshake
// request  | req_type, owner_handle, device_handle                | start && !busy
// result   | status, free_slots, freed_device, freed_valid, last  | out_valid, one cycle
//
// each request walks the row of slot cells, one cell per cycle, and a final
// close then emits one beat per released device. the chain length sets the
// rate. reset clears every slot at once.
// results cannot be stalled; busy stays high until the last beat is presented.
module handle_refcount_device_table #(
    parameter int OWNER_SLOTS = 64,
    parameter int DEVICES_PER_OWNER = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [2:0]                      req_type,
    input  logic [hrdt_pkg::HANDLE_W-1:0]   owner_handle,
    input  logic [hrdt_pkg::HANDLE_W-1:0]   device_handle,
    output logic                            out_valid,
    output logic [2:0]                      status,
    output logic [3:0]                      free_slots,
    output logic [hrdt_pkg::HANDLE_W-1:0]   freed_device,
    output logic                            freed_valid,
    output logic                            last
);
    import hrdt_pkg::*;

    localparam int DEV = DEVICES_PER_OWNER;
    localparam int IW  = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
    localparam int CW  = $clog2(OWNER_SLOTS + 1);
    localparam int JW  = (DEV > 1) ? $clog2(DEV) : 1;

    typedef logic [DEV-1:0][HANDLE_W-1:0] devs_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] owner;
        logic [COUNT_W-1:0]  count;
        logic [DCNT_W-1:0]   dcnt;
        devs_t               devs;
    } slot_t;

    typedef struct packed {
        logic          found;
        logic [IW-1:0] fidx;
        slot_t         fslot;
        logic          has_empty;
        logic [IW-1:0] eidx;
    } scan_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0] req_reg;
    logic [HANDLE_W-1:0] fh_reg, dh_reg;
    devs_t emit_devs_reg, emit_devs_next;
    logic [DEV-1:0] emit_mask_reg, emit_mask_next;

    logic out_valid_reg, out_valid_next;
    logic [2:0] status_reg, status_next;
    logic [3:0] free_slots_reg, free_slots_next;
    logic [HANDLE_W-1:0] freed_device_reg, freed_device_next;
    logic freed_valid_reg, freed_valid_next;
    logic last_reg, last_next;

    scan_t chain [OWNER_SLOTS+1];
    logic wr_en;
    logic [IW-1:0] wr_idx;
    slot_t wr_slot;

    assign chain[0] = '0;

    genvar g;
    generate
        for (g = 0; g < OWNER_SLOTS; g++)
        begin : g_cell
            hrdt_cell #(
                .IW(IW),
                .IDX(g),
                .slot_t(slot_t),
                .scan_t(scan_t)
            ) u_cell (
                .clk(clk),
                .rst_n(rst_n),
                .key(fh_reg),
                .scan_in(chain[g]),
                .scan_out(chain[g+1]),
                .wr_en(wr_en),
                .wr_idx(wr_idx),
                .wr_slot(wr_slot)
            );
        end
    endgenerate

    scan_t sc;
    logic invalid;
    logic zero_hit, dev_hit;
    logic [JW-1:0] zero_j, dev_j;
    logic [DEV-1:0] held_mask;
    logic [JW-1:0] low_j;
    logic [DEV-1:0] low_bit;

    always_comb
    begin
        sc = chain[OWNER_SLOTS];
        invalid = (req_reg > REQ_REMOVE) || (fh_reg == '0) ||
                  ((req_reg == REQ_ADD || req_reg == REQ_REMOVE) && dh_reg == '0);
        zero_hit = 1'b0;
        zero_j   = '0;
        dev_hit  = 1'b0;
        dev_j    = '0;
        for (int j = DEV - 1; j >= 0; j--)
        begin
            held_mask[j] = (sc.fslot.devs[j] != '0);
            if (sc.fslot.devs[j] == '0)
            begin
                zero_hit = 1'b1;
                zero_j   = JW'(j);
            end
            if (sc.fslot.devs[j] == dh_reg)
            begin
                dev_hit = 1'b1;
                dev_j   = JW'(j);
            end
        end
        low_j = '0;
        for (int j = DEV - 1; j >= 0; j--)
        begin
            if (emit_mask_reg[j])
            begin
                low_j = JW'(j);
            end
        end
        low_bit = '0;
        low_bit[low_j] = 1'b1;
    end

    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        emit_devs_next    = emit_devs_reg;
        emit_mask_next    = emit_mask_reg;
        out_valid_next    = 1'b0;
        status_next       = ST_OK;
        free_slots_next   = '0;
        freed_device_next = '0;
        freed_valid_next  = 1'b0;
        last_next         = 1'b1;
        wr_en             = 1'b0;
        wr_idx            = sc.fidx;
        wr_slot           = sc.fslot;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                    cnt_next   = '0;
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(OWNER_SLOTS))
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (invalid)
                    begin
                        status_next = ST_INVALID;
                    end
                    else if (req_reg == REQ_OPEN)
                    begin
                        if (sc.found)
                        begin
                            wr_en = 1'b1;
                            if (sc.fslot.count != COUNT_MAX)
                            begin
                                wr_slot.count = sc.fslot.count + 1'b1;
                            end
                        end
                        else if (sc.has_empty)
                        begin
                            wr_en         = 1'b1;
                            wr_idx        = sc.eidx;
                            wr_slot       = '0;
                            wr_slot.owner = fh_reg;
                            wr_slot.count = COUNT_W'(1);
                        end
                        else
                        begin
                            status_next = ST_TABLE_FULL;
                        end
                    end
                    else if (req_reg == REQ_QUERY)
                    begin
                        if (!sc.found)
                        begin
                            free_slots_next = 4'(DEV);
                        end
                        else if (sc.fslot.dcnt <= 4'(DEV))
                        begin
                            free_slots_next = 4'(DEV) - sc.fslot.dcnt;
                        end
                    end
                    else if (!sc.found)
                    begin
                        status_next = ST_NO_OWNER;
                    end
                    else if (req_reg == REQ_CLOSE)
                    begin
                        wr_en = 1'b1;
                        if (sc.fslot.count > COUNT_W'(1))
                        begin
                            wr_slot.count = sc.fslot.count - 1'b1;
                        end
                        else
                        begin
                            wr_slot = '0;
                            if (held_mask != '0)
                            begin
                                // released devices go out one beat per cycle
                                out_valid_next = 1'b0;
                                emit_devs_next = sc.fslot.devs;
                                emit_mask_next = held_mask;
                                state_next     = S_EMIT;
                            end
                        end
                    end
                    else if (req_reg == REQ_ADD)
                    begin
                        if (sc.fslot.dcnt >= 4'(DEV) || !zero_hit)
                        begin
                            status_next = ST_LIST_FULL;
                        end
                        else
                        begin
                            wr_en                 = 1'b1;
                            wr_slot.devs[zero_j]  = dh_reg;
                            wr_slot.dcnt          = sc.fslot.dcnt + 1'b1;
                        end
                    end
                    else
                    begin
                        if (sc.fslot.dcnt != '0 && dev_hit)
                        begin
                            wr_en                = 1'b1;
                            wr_slot.devs[dev_j]  = '0;
                            wr_slot.dcnt         = sc.fslot.dcnt - 1'b1;
                        end
                        else
                        begin
                            status_next = ST_NOT_HELD;
                        end
                    end
                end
            end
            S_EMIT:
            begin
                out_valid_next    = 1'b1;
                freed_device_next = emit_devs_reg[low_j];
                freed_valid_next  = 1'b1;
                emit_mask_next    = emit_mask_reg & ~low_bit;
                last_next         = (emit_mask_next == '0);
                if (last_next)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            req_reg <= req_type;
            fh_reg  <= owner_handle;
            dh_reg  <= device_handle;
        end
        cnt_reg          <= cnt_next;
        emit_devs_reg    <= emit_devs_next;
        emit_mask_reg    <= emit_mask_next;
        status_reg       <= status_next;
        free_slots_reg   <= free_slots_next;
        freed_device_reg <= freed_device_next;
        freed_valid_reg  <= freed_valid_next;
        last_reg         <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign free_slots   = free_slots_reg;
    assign freed_device = freed_device_reg;
    assign freed_valid  = freed_valid_reg;
    assign last         = last_reg;

endmodule

>>> rtl/hrdt_cell.sv
`timescale 1ns / 1ps
module hrdt_cell #(
    parameter int IW = 6,
    parameter int IDX = 0,
    parameter type slot_t = logic,
    parameter type scan_t = logic
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [hrdt_pkg::HANDLE_W-1:0]   key,
    input  scan_t                           scan_in,
    output scan_t                           scan_out,
    input  logic                            wr_en,
    input  logic [IW-1:0]                   wr_idx,
    input  slot_t                           wr_slot
);
    import hrdt_pkg::*;

    slot_t slot_reg;
    scan_t scan_reg;
    scan_t scan_next;

    always_comb
    begin
        scan_next = scan_in;
        // first match and lowest empty slot win, so later cells only fill gaps
        if (!scan_in.found && key != '0 && slot_reg.owner == key)
        begin
            scan_next.found = 1'b1;
            scan_next.fidx  = IW'(IDX);
            scan_next.fslot = slot_reg;
        end
        if (!scan_in.has_empty && slot_reg.owner == '0)
        begin
            scan_next.has_empty = 1'b1;
            scan_next.eidx      = IW'(IDX);
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
        end
        else if (wr_en && wr_idx == IW'(IDX))
        begin
            slot_reg <= wr_slot;
        end
    end

    assign scan_out = scan_reg;

endmodule

>>> tb/tb_handle_refcount_device_table.sv
`timescale 1ns / 1ps
module tb_handle_refcount_device_table;
    import hrdt_pkg::*;

    localparam int SLOTS = 64;
    localparam int DEVS = 8;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  free_slots;
        logic [15:0] freed_device;
        logic        freed_valid;
        logic        last;
    } table_result_t;

    int mismatches = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        begin
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $time);
            mismatches++;
        end
    endtask

    class owner_table_sb;
        logic [15:0] owner[SLOTS];
        logic [15:0] open_cnt[SLOTS];
        logic [3:0]  dev_cnt[SLOTS];
        logic [15:0] dev_store[SLOTS][DEVS];
        table_result_t pending[$];

        function new();
            foreach (owner[i])
            begin
                owner[i] = '0;
                open_cnt[i] = '0;
                dev_cnt[i] = '0;
                for (int j = 0; j < DEVS; j++)
                    dev_store[i][j] = '0;
            end
        endfunction

        function void push(input logic [2:0] st, input logic [3:0] fs,
                           input logic [15:0] dev, input logic vld, input logic lst);
            table_result_t r;
            r.status = st;
            r.free_slots = fs;
            r.freed_device = dev;
            r.freed_valid = vld;
            r.last = lst;
            pending.push_back(r);
        endfunction

        function int slot_of(input logic [15:0] h);
            for (int i = 0; i < SLOTS; i++)
                if (owner[i] == h)
                    return i;
            return -1;
        endfunction

        function void note_request(input logic [2:0] req, input logic [15:0] fh,
                                   input logic [15:0] dh);
            int s;
            int n;
            bit done;
            done = 0;
            if (req > REQ_REMOVE || fh == 0 || ((req == REQ_ADD || req == REQ_REMOVE) && dh == 0))
            begin
                push(ST_INVALID, 0, 0, 0, 1);
                return;
            end
            s = slot_of(fh);
            case (req)
                REQ_OPEN:
                begin
                    if (s >= 0)
                    begin
                        if (open_cnt[s] != COUNT_MAX)
                            open_cnt[s]++;
                        push(ST_OK, 0, 0, 0, 1);
                    end
                    else
                    begin
                        s = slot_of(16'd0);
                        if (s < 0)
                            push(ST_TABLE_FULL, 0, 0, 0, 1);
                        else
                        begin
                            owner[s] = fh;
                            open_cnt[s] = 1;
                            dev_cnt[s] = 0;
                            for (int j = 0; j < DEVS; j++)
                                dev_store[s][j] = 0;
                            push(ST_OK, 0, 0, 0, 1);
                        end
                    end
                end
                REQ_QUERY:
                    push(ST_OK, (s < 0) ? 4'(DEVS) : 4'(DEVS - dev_cnt[s]), 0, 0, 1);
                default:
                begin
                    if (s < 0)
                        push(ST_NO_OWNER, 0, 0, 0, 1);
                    else if (req == REQ_CLOSE)
                    begin
                        if (open_cnt[s] > 1)
                        begin
                            open_cnt[s]--;
                            push(ST_OK, 0, 0, 0, 1);
                        end
                        else
                        begin
                            open_cnt[s] = 0;
                            owner[s] = 0;
                            dev_cnt[s] = 0;
                            n = 0;
                            for (int j = 0; j < DEVS; j++)
                                if (dev_store[s][j] != 0)
                                begin
                                    push(ST_OK, 0, dev_store[s][j], 1, 0);
                                    dev_store[s][j] = 0;
                                    n++;
                                end
                            if (n == 0)
                                push(ST_OK, 0, 0, 0, 1);
                            else
                                pending[$].last = 1;
                        end
                    end
                    else if (req == REQ_ADD)
                    begin
                        if (dev_cnt[s] < DEVS)
                            for (int j = 0; j < DEVS && !done; j++)
                                if (dev_store[s][j] == 0)
                                begin
                                    dev_store[s][j] = dh;
                                    dev_cnt[s]++;
                                    done = 1;
                                end
                        push(done ? ST_OK : ST_LIST_FULL, 0, 0, 0, 1);
                    end
                    else
                    begin
                        if (dev_cnt[s] != 0)
                            for (int j = 0; j < DEVS && !done; j++)
                                if (dev_store[s][j] == dh)
                                begin
                                    dev_store[s][j] = 0;
                                    dev_cnt[s]--;
                                    done = 1;
                                end
                        push(done ? ST_OK : ST_NOT_HELD, 0, 0, 0, 1);
                    end
                end
            endcase
        endfunction

        task check_result(input table_result_t got);
            table_result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected beat", 32'(got), 32'd0);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status)
                report("status", 32'(got.status), 32'(want.status));
            if (got.free_slots !== want.free_slots)
                report("free_slots", 32'(got.free_slots), 32'(want.free_slots));
            if (got.freed_device !== want.freed_device)
                report("freed_device", 32'(got.freed_device), 32'(want.freed_device));
            if (got.freed_valid !== want.freed_valid)
                report("freed_valid", 32'(got.freed_valid), 32'(want.freed_valid));
            if (got.last !== want.last)
                report("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [2:0] req_type = '0;
    logic [15:0] owner_handle = '0;
    logic [15:0] device_handle = '0;
    logic out_valid;
    logic [2:0] status;
    logic [3:0] free_slots;
    logic [15:0] freed_device;
    logic freed_valid;
    logic last;

    owner_table_sb sb = new();
    int idle_cycles = 0;
    logic [15:0] handle_pool[8];

    always #5 clk = ~clk;

    handle_refcount_device_table u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .owner_handle(owner_handle), .device_handle(device_handle),
        .out_valid(out_valid), .status(status), .free_slots(free_slots),
        .freed_device(freed_device), .freed_valid(freed_valid), .last(last)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid)
                sb.check_result({status, free_slots, freed_device, freed_valid, last});
            if ((start && !busy) || out_valid)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_handle_refcount_device_table failed");
                $finish;
            end
        end
    end

    // with no gap start stays high for the next beat
    task automatic request_gap();
        int g;
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: g = 0;
                9: g = $urandom_range(20, 120);
                default: g = $urandom_range(1, 4);
            endcase
            if (g > 0)
            begin
                start <= 0;
                repeat (g) @(negedge clk);
            end
        end
    endtask

    // hold start until the beat is taken, then note it
    task automatic send_request(input logic [2:0] req, input logic [15:0] fh,
                                input logic [15:0] dh);
        begin
            req_type <= req;
            owner_handle <= fh;
            device_handle <= dh;
            start <= 1;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            sb.note_request(req, fh, dh);
            @(negedge clk);
            request_gap();
        end
    endtask

    task automatic send_random();
        logic [15:0] fh;
        logic [15:0] dh;
        int k;
        begin
            k = $urandom_range(0, 19);
            fh = (k == 0) ? 16'($urandom) : (k == 1) ? 16'd0 : handle_pool[$urandom_range(0, 7)];
            k = $urandom_range(0, 19);
            dh = (k == 0) ? 16'd0 : (k < 4) ? 16'($urandom) : 16'($urandom_range(1, 6));
            k = $urandom_range(0, 99);
            if (k < 25)
                send_request(REQ_OPEN, fh, dh);
            else if (k < 45)
                send_request(REQ_CLOSE, fh, dh);
            else if (k < 55)
                send_request(REQ_QUERY, fh, dh);
            else if (k < 80)
                send_request(REQ_ADD, fh, dh);
            else if (k < 97)
                send_request(REQ_REMOVE, fh, dh);
            else
                send_request(3'($urandom_range(5, 7)), fh, dh);
        end
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: invalid forms and every kind on a fresh owner
        send_request(3'd7, 16'h1234, 16'h1);
        send_request(REQ_OPEN, 16'h0000, 16'h1);
        send_request(REQ_ADD, 16'hFFFF, 16'h0);
        send_request(REQ_QUERY, 16'hABCD, 16'h0);
        send_request(REQ_CLOSE, 16'hABCD, 16'h0);
        send_request(REQ_REMOVE, 16'hABCD, 16'h5);
        send_request(REQ_OPEN, 16'hFFFF, 16'h0);
        send_request(REQ_REMOVE, 16'hFFFF, 16'h5);
        for (int j = 0; j < 9; j++)
            send_request(REQ_ADD, 16'hFFFF, (j == 0) ? 16'hFFFF : (j == 1) ? 16'hFFFF : 16'(j));
        send_request(REQ_QUERY, 16'hFFFF, 16'h0);
        send_request(REQ_REMOVE, 16'hFFFF, 16'h3);
        send_request(REQ_REMOVE, 16'hFFFF, 16'h3);
        send_request(REQ_OPEN, 16'hFFFF, 16'h0);
        send_request(REQ_CLOSE, 16'hFFFF, 16'h0);
        send_request(REQ_CLOSE, 16'hFFFF, 16'h0);

        // fill the table, one more open, then drain it
        for (int i = 1; i <= SLOTS; i++)
            send_request(REQ_OPEN, 16'(i), 16'h0);
        send_request(REQ_OPEN, 16'h8000, 16'h0);
        for (int i = 1; i <= SLOTS; i++)
            send_request(REQ_CLOSE, 16'(i), 16'h0);

        foreach (handle_pool[i])
            handle_pool[i] = 16'($urandom_range(1, 65535));
        handle_pool[0] = 16'hFFFF;
        for (int n = 0; n < 100; n++)
            send_random();
        start <= 0;

        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (SLOTS + 20) @(negedge clk);
        if (mismatches == 0 && sb.pending.size() == 0)
            $display("tb_handle_refcount_device_table passed");
        else
            $display("tb_handle_refcount_device_table failed");
        $finish;
    end
endmodule
